[rtl/lifegen_pkg.sv]
package lifegen_pkg;

    // 3x3 neighborhood: top row in bits 0..2, middle row 3..5, bottom row 6..8,
    // newest column in the low bit of each group
    typedef logic [8:0] t_window;

    localparam int WINDOW_BITS = 9;
    localparam int CENTER_BIT  = 4;

    // B3/S23
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

[rtl/lifegen_ram.sv]
module lifegen_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/lifegen_rule.sv]
module lifegen_rule (
    input  lifegen_pkg::t_window i_window,
    output logic                 o_next_alive
);

    logic [3:0] count;
    logic       center;

    // eight-neighbor popcount, center excluded
    always_comb begin
        count = 4'd0;
        for (int k = 0; k < lifegen_pkg::WINDOW_BITS; k++) begin
            if (k != lifegen_pkg::CENTER_BIT) begin
                count = count + 4'(i_window[k]);
            end
        end
    end

    assign center = i_window[lifegen_pkg::CENTER_BIT];

    assign o_next_alive = (count == lifegen_pkg::BIRTH_COUNT) ||
                          (center && (count == lifegen_pkg::SURVIVE_COUNT));

endmodule

[rtl/life_automaton_generation_step.sv]
// Next-generation engine for Conway's Life (B3/S23) on a bounded grid whose
// border cells are always dead. The current generation streams in one cell
// per transfer in raster order; a new cell is taken every cycle unless the
// output register holds a result that is not taken, and the result for the
// cell one row up and one column left passes through the registered read of
// the line-store RAM, then the window update, neighbor count and output register.
// The first row and first column of input give no result; the last row and
// column are never reported. Border cells are reported as dead. A write to
// either size register restarts the generation at row 0, column 0; sizes are
// clamped to [3, MAX_COLUMNS] and [3, MAX_ROWS]. Write configuration only
// while the block is idle. The line stores need no clearing after reset:
// their contents before the first two rows are written only reach border cells.
module life_automaton_generation_step #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cell_alive,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_next_alive,
    output logic [15:0] o_cell_row,
    output logic [7:0]  o_cell_column,
    output logic        o_frame_last
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [31:0] MIN_SIZE   = 32'd3;
    localparam logic [31:0] RESET_SIZE = 32'd256;

    function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] res;
        if (v < MIN_SIZE) begin
            res = MIN_SIZE;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // configuration: clamped sizes
    logic [CW:0] r_cols;
    logic [RW:0] r_rows;
    logic        cfg_hit;

    assign cfg_hit = i_cfg_wr_en && (i_cfg_index == CFG_COLUMNS || i_cfg_index == CFG_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= (CW+1)'(clamp_size(RESET_SIZE, 32'(MAX_COLUMNS)));
            r_rows <= (RW+1)'(clamp_size(RESET_SIZE, 32'(MAX_ROWS)));
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_COLUMNS: begin
                    r_cols <= (CW+1)'(clamp_size(32'(i_cfg_data[8:0]), 32'(MAX_COLUMNS)));
                end
                CFG_ROWS: begin
                    r_rows <= (RW+1)'(clamp_size(32'(i_cfg_data), 32'(MAX_ROWS)));
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline handshake
    logic in_xfer;
    logic adv;
    logic r1_valid;
    logic r1_emit;
    logic r_out_valid;

    assign adv        = r1_valid && (!r1_emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r1_valid || adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    // raster position of the next incoming cell
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          last_col;
    logic          last_row;

    assign last_col = ({1'b0, r_col} + 1'b1) >= r_cols;
    assign last_row = ({1'b0, r_row} + 1'b1) >= r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xfer) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage 1: cell accepted, line-store read in flight
    logic          r1_bit;
    logic          r1_interior;
    logic          r1_frame_last;
    logic [CW-1:0] r1_col;
    logic [RW-1:0] r1_cr;
    logic [CW-1:0] r1_cc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r1_emit  <= 1'b0;
        end else if (in_xfer) begin
            r1_valid <= 1'b1;
            r1_emit  <= (r_row != '0) && (r_col != '0);
        end else if (adv) begin
            r1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r1_bit        <= i_cell_alive;
            r1_col        <= r_col;
            r1_cr         <= r_row - 1'b1;
            r1_cc         <= r_col - 1'b1;
            r1_interior   <= (r_row > RW'(1)) && (r_col > CW'(1));
            r1_frame_last <= last_col && last_row;
        end
    end

    // line stores: bit 1 upper row, bit 0 middle row
    logic       ram_wr_en;
    logic [1:0] ram_wr_data;
    logic [1:0] ram_rd_data;
    logic [1:0] rd_eff;
    logic       r_fwd_hit;
    logic [1:0] r_fwd_data;

    assign ram_wr_en   = adv;
    assign ram_wr_data = {rd_eff[0], r1_bit};

    lifegen_ram #(
        .WIDTH(2),
        .DEPTH(MAX_COLUMNS)
    ) u_line_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(r1_col),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (in_xfer),
        .i_rd_addr(r_col),
        .o_rd_data(ram_rd_data)
    );

    // bypass when the read hits the column being written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (in_xfer) begin
            r_fwd_hit <= ram_wr_en && (r1_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_fwd_data <= ram_wr_data;
        end
    end

    assign rd_eff = r_fwd_hit ? r_fwd_data : ram_rd_data;

    // window shift and rule
    lifegen_pkg::t_window r_window;
    lifegen_pkg::t_window n_window;
    logic                 rule_alive;

    assign n_window = ((r_window << 1) & 9'h1B6)
                    | {2'b00, r1_bit, 2'b00, rd_eff[0], 2'b00, rd_eff[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (adv) begin
            r_window <= n_window;
        end
    end

    lifegen_rule u_rule (
        .i_window    (n_window),
        .o_next_alive(rule_alive)
    );

    // output register
    logic        r_next_alive;
    logic [15:0] r_cell_row;
    logic [7:0]  r_cell_column;
    logic        r_frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r1_emit) begin
            r_next_alive  <= r1_interior && rule_alive;
            r_cell_row    <= 16'(32'(r1_cr));
            r_cell_column <= 8'(32'(r1_cc));
            r_frame_last  <= r1_frame_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_alive  = r_next_alive;
    assign o_cell_row    = r_cell_row;
    assign o_cell_column = r_cell_column;
    assign o_frame_last  = r_frame_last;

endmodule

[tb/life_tb_pkg.sv]
`timescale 1ns / 1ps

package life_tb_pkg;

    // configuration register map; indexes past the size registers are ignored
    typedef enum logic [1:0] {
        REG_GRID_COLUMNS = 2'd0,
        REG_GRID_ROWS    = 2'd1,
        REG_SPARE_A      = 2'd2,
        REG_SPARE_B      = 2'd3
    } t_reg_index;

    // must match the block's parameters
    localparam int GRID_MAX_COLUMNS = 256;
    localparam int GRID_MAX_ROWS    = 65535;

endpackage

[tb/life_checker.sv]
`timescale 1ns / 1ps

module life_checker
    import lifegen_pkg::*;
    import life_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_cell_alive,

    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_next_alive,
    input  logic [15:0] i_cell_row,
    input  logic [7:0]  i_cell_column,
    input  logic        i_frame_last,

    output int          o_pending,
    output int          o_fail_count
);

    typedef struct packed {
        logic        next_alive;
        logic [15:0] row;
        logic [7:0]  column;
        logic        last;
    } t_cell_result;

    // predictor state
    logic [8:0]                  grid_columns_q;
    logic [15:0]                 grid_rows_q;
    logic [GRID_MAX_COLUMNS-1:0] row_above2;
    logic [GRID_MAX_COLUMNS-1:0] row_above1;
    t_window                     window_q;
    logic [15:0]                 row_ctr;
    logic [7:0]                  col_ctr;

    t_cell_result next_gen_q[$];
    int           mismatches;

    function automatic int clamp_size(int v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // push one incoming cell through the line stores and window, advance the raster
    task automatic step_generation(input logic cell_bit, output bit produced,
                                   output t_cell_result res);
        int   cols;
        int   rows;
        int   c;
        int   r;
        int   n;
        int   k;
        logic up;
        logic mid;
        bit   last_col;
        bit   last_row;
        cols = clamp_size(int'(grid_columns_q), GRID_MAX_COLUMNS);
        rows = clamp_size(int'(grid_rows_q), GRID_MAX_ROWS);
        c    = int'(col_ctr);
        r    = int'(row_ctr);

        up  = row_above2[c];
        mid = row_above1[c];
        row_above2[c] = mid;
        row_above1[c] = cell_bit;

        // shift each row group left by one, newest column enters the low bit
        window_q = {window_q[7:6], cell_bit, window_q[4:3], mid, window_q[1:0], up};

        last_col = (c + 1 >= cols);
        last_row = (r + 1 >= rows);
        produced = (r >= 1) && (c >= 1);
        res      = '0;
        if (produced) begin
            res.row    = 16'(r - 1);
            res.column = 8'(c - 1);
            res.last   = last_col && last_row;
            // border cells stay dead
            if (r >= 2 && c >= 2) begin
                n = 0;
                for (k = 0; k < WINDOW_BITS; k++) begin
                    if (k != CENTER_BIT) n += int'(window_q[k]);
                end
                res.next_alive = (n == BIRTH_COUNT) ||
                                 (window_q[CENTER_BIT] && n == SURVIVE_COUNT);
            end
        end

        if (last_col) begin
            col_ctr = '0;
            row_ctr = last_row ? 16'd0 : 16'(r + 1);
        end else begin
            col_ctr = 8'(c + 1);
        end
    endtask

    // watch the channels: compare results, track config, predict on input transfers
    always @(posedge i_clk) begin : watch
        t_cell_result want;
        t_cell_result got;
        bit           produced;
        if (!i_rst_n) begin
            grid_columns_q = 9'd256;
            grid_rows_q    = 16'd256;
            row_above2     = '0;
            row_above1     = '0;
            window_q       = '0;
            row_ctr        = '0;
            col_ctr        = '0;
            mismatches     = 0;
            next_gen_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_next_alive, i_cell_row, i_cell_column, i_frame_last};
                if (next_gen_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result alive=%0d row=%0d col=%0d last=%0d",
                                 $time, got.next_alive, got.row, got.column, got.last);
                end else begin
                    want = next_gen_q.pop_front();
                    if (got.next_alive !== want.next_alive || got.row !== want.row ||
                        got.column !== want.column || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch expected alive=%0d row=%0d col=%0d last=%0d",
                                     $time, want.next_alive, want.row, want.column,
                                     want.last);
                            $display("    got alive=%0d row=%0d col=%0d last=%0d",
                                     got.next_alive, got.row, got.column, got.last);
                        end
                    end
                end
            end

            // any size write restarts the generation
            if (i_cfg_wr_en) begin
                case (t_reg_index'(i_cfg_index))
                    REG_GRID_COLUMNS: begin
                        grid_columns_q = i_cfg_data[8:0];
                        row_ctr        = '0;
                        col_ctr        = '0;
                    end
                    REG_GRID_ROWS: begin
                        grid_rows_q = i_cfg_data;
                        row_ctr     = '0;
                        col_ctr     = '0;
                    end
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                step_generation(i_cell_alive, produced, want);
                if (produced) next_gen_q.push_back(want);
            end
        end
        o_pending    <= next_gen_q.size();
        o_fail_count <= mismatches;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import life_tb_pkg::*;

    localparam int ITEM_TARGET  = 1450;
    localparam int IDLE_MAX     = 5;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        cell_alive;
    logic        out_valid;
    logic        out_ready;
    logic        next_alive;
    logic [15:0] cell_row;
    logic [7:0]  cell_column;
    logic        frame_last;

    int pending;
    int fail_count;
    bit tx_no_idle;
    bit rx_no_idle;
    int rx_stall;

    life_automaton_generation_step uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_cell_alive (cell_alive),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_next_alive (next_alive),
        .o_cell_row   (cell_row),
        .o_cell_column(cell_column),
        .o_frame_last (frame_last)
    );

    life_checker next_gen_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_cell_alive (cell_alive),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_next_alive (next_alive),
        .i_cell_row   (cell_row),
        .i_cell_column(cell_column),
        .i_frame_last (frame_last),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: random stall after each transfer unless running flat out
    always @(posedge clk) begin : receive_side
        int stall_draw;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_stall  <= 0;
        end else if (out_valid && out_ready) begin
            stall_draw = rx_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            rx_stall  <= stall_draw;
            out_ready <= (stall_draw == 0);
        end else if (rx_stall > 0) begin
            rx_stall  <= rx_stall - 1;
            out_ready <= (rx_stall == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_cell(input logic v);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cell_alive <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // 3x3 generation, bit 0 first in raster order
    task automatic send_pattern(input logic [8:0] cells);
        int k;
        for (k = 0; k < 9; k++) send_cell(cells[k]);
    endtask

    // stop sending and let every outstanding result (and silent items) flush
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input t_reg_index idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [15:0] cols_val, input logic [15:0] rows_val,
                            input bit with_spare);
        wait_drained();
        cfg_write(REG_GRID_COLUMNS, cols_val);
        cfg_write(REG_GRID_ROWS, rows_val);
        if (with_spare)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        int          fed;
        int          phase;
        int          cols_raw;
        int          rows_raw;
        int          cols_eff;
        int          rows_eff;
        int          count;
        int          density;
        int          pause_at;
        int          i;
        logic [15:0] cols_val;
        logic [15:0] rows_val;

        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_GRID_COLUMNS;
        cfg_data   = '0;
        in_valid   = 1'b0;
        cell_alive = 1'b0;
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest grid: crowded center dies, diagonal center survives,
        // birth from a full top row with sizes written below the minimum
        set_grid(16'd3, 16'd3, 1'b0);
        send_pattern(9'b111_111_111);
        send_pattern(9'b100_010_001);
        set_grid(16'd2, 16'd0, 1'b1);
        send_pattern(9'b000_000_111);

        fed   = 0;
        phase = 0;
        while (fed < ITEM_TARGET) begin
            tx_no_idle <= ($urandom_range(0, 3) == 0);
            rx_no_idle <= ($urandom_range(0, 3) == 0);
            density = $urandom_range(5, 95);

            if (phase == 2) begin
                // widest grid, column register written above the maximum or at it
                cols_val = {7'($urandom), 1'b1, 8'($urandom)};
                set_grid(cols_val, 16'd3, $urandom_range(0, 1));
                count = 3 * GRID_MAX_COLUMNS + $urandom_range(0, 20);
            end else if (phase == 4 || phase == 9) begin
                // very tall grid, only partly streamed before the next restart
                rows_val = (phase == 4) ? 16'hFFFF : 16'($urandom_range(1000, 65534));
                set_grid(16'($urandom_range(3, 10)), rows_val, 1'b0);
                count = $urandom_range(40, 120);
            end else if (phase % 7 == 5) begin
                // unused index only: the generation carries on
                wait_drained();
                cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
                cfg_wr_en <= 1'b0;
                @(posedge clk);
                count = $urandom_range(5, 40);
            end else begin
                cols_raw = $urandom_range(0, 12);
                rows_raw = $urandom_range(0, 10);
                cols_eff = (cols_raw < 3) ? 3 : cols_raw;
                rows_eff = (rows_raw < 3) ? 3 : rows_raw;
                // upper bits of the column write are outside the register
                cols_val = {7'($urandom), 9'(cols_raw)};
                rows_val = 16'(rows_raw);
                set_grid(cols_val, rows_val, ($urandom_range(0, 3) == 0));
                count = $urandom_range(1, 2) * cols_eff * rows_eff +
                        $urandom_range(0, cols_eff * rows_eff - 1);
            end

            pause_at = (phase == 1) ? count / 2 : -1;
            for (i = 0; i < count; i++) begin
                if (i == pause_at) wait_drained();
                send_cell($urandom_range(0, 99) < density);
                fed++;
            end
            phase++;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/lifegen_pkg.sv
rtl/lifegen_ram.sv
rtl/lifegen_rule.sv
rtl/life_automaton_generation_step.sv
tb/life_tb_pkg.sv
tb/life_checker.sv
tb/tb.sv
